>>> design/integer_literal_parser_assert.svh
// ----------------------------------------------------------------------------
// integer_literal_parser_assert.svh
// Assertion macros shared by the parser RTL. Clock clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// ante holds in this cycle, so cons must hold in the same cycle
`define ILP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("integer_literal_parser: same-cycle check failed");

// ante holds in this cycle, so cons must hold in the next one
`define ILP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("integer_literal_parser: next-cycle check failed");

`endif

>>> design/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Types, codes and accumulator helpers for the integer literal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

	localparam logic [1:0] KIND_INVALID = 2'd0;
	localparam logic [1:0] KIND_DEC     = 2'd1;
	localparam logic [1:0] KIND_HEX     = 2'd2;
	localparam logic [1:0] KIND_BIN     = 2'd3;

	localparam logic [1:0] BASE_2  = 2'd0;
	localparam logic [1:0] BASE_10 = 2'd1;
	localparam logic [1:0] BASE_16 = 2'd2;

	localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;
	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_ONE   = 8'h31; // '1'
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic [1:0]  pos;       // characters taken, saturating at 2
		logic        bin_open;
		logic        bin_found;
		logic [63:0] bin_val;
		logic        hex_mode;
		logic        hex_seen;
		logic        dec_seen;
		logic [63:0] num_val;
		logic        neg;
		logic        stop;
		logic        bad;
		logic        ended;     // zero byte seen
	} scan_state_t;

	localparam scan_state_t ST_RESET = '{
		pos: 2'd0, bin_open: 1'b1, bin_found: 1'b0, bin_val: 64'd0,
		hex_mode: 1'b0, hex_seen: 1'b0, dec_seen: 1'b0, num_val: 64'd0,
		neg: 1'b0, stop: 1'b0, bad: 1'b0, ended: 1'b0};

	// finished literal: kind plus magnitude, sign applied in the output stage
	typedef struct packed {
		logic [1:0]  kind;
		logic        neg;
		logic [63:0] mag;
	} lit_res_t;

	// m*base + d, capped at 2^63; m never exceeds the cap, so 68 bits hold it
	function automatic logic [63:0] push_mag(input logic [63:0] m, input logic [1:0] base_sel,
			input logic [3:0] d);
		logic [67:0] prod;
		logic [67:0] sum;
		unique case (base_sel)
			BASE_2:  prod = {3'd0, m, 1'b0};
			BASE_10: prod = {1'b0, m, 3'd0} + {3'd0, m, 1'b0};
			BASE_16: prod = {m, 4'd0};
			default: prod = 68'd0;
		endcase
		sum = prod + {64'd0, d};
		if (sum > {4'd0, MAG_CAP})
			return MAG_CAP;
		return sum[63:0];
	endfunction

	// {is hex digit, digit value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return {1'b1, 4'(c - CH_ZERO)};
		if (c >= CH_LO_A && c <= CH_LO_F)
			return {1'b1, 4'(c - CH_LO_A + 8'd10)};
		if (c >= CH_UP_A && c <= CH_UP_F)
			return {1'b1, 4'(c - CH_UP_A + 8'd10)};
		return 5'd0;
	endfunction

endpackage

`default_nettype wire

>>> design/integer_literal_parser.sv
// ----------------------------------------------------------------------------
// integer_literal_parser
// Integer literal lexer: decimal, hexadecimal and binary, 64-bit saturating.
// ----------------------------------------------------------------------------
// Takes one character per cycle while item_stall is low. The last character
// passes through the input register (_s1) and the finished-literal register
// (_s2) to the result register; the next literal's characters can follow it
// directly. The clock period is set by the per-character accumulator step
// (64-bit shift-add by 2, 10 or 16 and the saturation compare). Only the item
// with last set gives a result; a stall on the result side holds back the input
// only when a last character waits while the result and _s2 registers both hold a finished literal.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_literal_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [7:0]         ch,
	input  wire logic               last,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [1:0]              kind,
	output logic signed [63:0]      value
);

	logic              v_s1;
	logic [7:0]        ch_s1;
	logic              last_s1;
	logic              leave;
	logic              pop;
	logic              res_v_s2;
	ilp_pkg::lit_res_t res_s2;
	logic              take;

	assign item_stall = v_s1 && !leave;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (take)
				v_s1 <= 1'b1;
			else if (leave)
				v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	ilp_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s1     (v_s1),
		.ch_s1    (ch_s1),
		.last_s1  (last_s1),
		.pop      (pop),
		.leave    (leave),
		.res_v_s2 (res_v_s2),
		.res_s2   (res_s2)
	);

	ilp_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_v_s2     (res_v_s2),
		.res_s2       (res_s2),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.value        (value)
	);

endmodule

`default_nettype wire

>>> design/ilp_scan.sv
// ----------------------------------------------------------------------------
// ilp_scan
// Per-character scanner state and the finished-literal register (_s2).
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_literal_parser_assert.svh"

module ilp_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              v_s1,
	input  wire logic [7:0]        ch_s1,
	input  wire logic              last_s1,
	input  wire logic              pop,
	output logic                   leave,
	output logic                   res_v_s2,
	output ilp_pkg::lit_res_t      res_s2
);

	ilp_pkg::scan_state_t st_q;
	ilp_pkg::scan_state_t st_d;
	ilp_pkg::lit_res_t    res_d;
	logic                 s2_ready;

	assign s2_ready = !res_v_s2 || pop;
	assign leave    = v_s1 && (!last_s1 || s2_ready);

	always_comb begin
		logic [4:0] hv;
		logic       is_dec;
		hv     = ilp_pkg::hex_val(ch_s1);
		is_dec = ch_s1 >= ilp_pkg::CH_ZERO && ch_s1 <= ilp_pkg::CH_NINE;
		st_d   = st_q;
		if (!st_q.ended) begin
			if (ch_s1 == ilp_pkg::CH_NUL) begin
				st_d.ended = 1'b1;
			end else begin
				// binary run from the start of the literal
				if (st_q.bin_open && !st_q.bin_found) begin
					if (ch_s1 == ilp_pkg::CH_ZERO || ch_s1 == ilp_pkg::CH_ONE) begin
						st_d.bin_val = ilp_pkg::push_mag(st_q.bin_val, ilp_pkg::BASE_2,
							{3'd0, ch_s1[0]});
					end else if (ch_s1 == ilp_pkg::CH_LO_B || ch_s1 == ilp_pkg::CH_UP_B) begin
						st_d.bin_found = 1'b1;
						st_d.bin_open  = 1'b0;
					end else begin
						st_d.bin_open = 1'b0;
					end
				end
				// decimal / hex scan
				if (!st_q.stop && !st_q.bad) begin
					priority if (st_q.pos == 2'd0 && ch_s1 == ilp_pkg::CH_MINUS) begin
						st_d.neg = 1'b1;
					end else if (st_q.pos == 2'd1 && !st_q.neg && st_q.dec_seen
							&& st_q.num_val == 64'd0
							&& (ch_s1 == ilp_pkg::CH_LO_X || ch_s1 == ilp_pkg::CH_UP_X)) begin
						st_d.hex_mode = 1'b1;
					end else if (st_q.hex_mode) begin
						if (hv[4]) begin
							st_d.num_val  = ilp_pkg::push_mag(st_q.num_val, ilp_pkg::BASE_16,
								hv[3:0]);
							st_d.hex_seen = 1'b1;
						end else if (ch_s1 == ilp_pkg::CH_SPACE && st_q.hex_seen) begin
							st_d.stop = 1'b1;
						end else begin
							st_d.bad = 1'b1;
						end
					end else if (is_dec) begin
						st_d.num_val  = ilp_pkg::push_mag(st_q.num_val, ilp_pkg::BASE_10,
							hv[3:0]);
						st_d.dec_seen = 1'b1;
					end else if (ch_s1 == ilp_pkg::CH_SPACE && !(st_q.neg && !st_q.dec_seen)) begin
						st_d.stop = 1'b1;
					end else begin
						st_d.bad = 1'b1;
					end
				end
				if (st_q.pos != 2'd2)
					st_d.pos = st_q.pos + 2'd1;
			end
		end
	end

	// classify from the state after this character
	always_comb begin
		res_d = '{kind: ilp_pkg::KIND_INVALID, neg: 1'b0, mag: 64'd0};
		priority if (st_d.pos == 2'd0) begin
			res_d.kind = ilp_pkg::KIND_INVALID;
		end else if (st_d.bin_found) begin
			res_d.kind = ilp_pkg::KIND_BIN;
			res_d.mag  = st_d.bin_val;
		end else if (st_d.bad) begin
			res_d.kind = ilp_pkg::KIND_INVALID;
		end else if (st_d.hex_mode) begin
			if (st_d.hex_seen) begin
				res_d.kind = ilp_pkg::KIND_HEX;
				res_d.mag  = st_d.num_val;
			end
		end else if (st_d.neg) begin
			if (st_d.dec_seen) begin
				res_d.kind = ilp_pkg::KIND_DEC;
				res_d.neg  = 1'b1;
				res_d.mag  = st_d.num_val;
			end
		end else begin
			res_d.kind = ilp_pkg::KIND_DEC;
			res_d.mag  = st_d.num_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ilp_pkg::ST_RESET;
			res_v_s2 <= 1'b0;
		end else begin
			if (leave)
				st_q <= last_s1 ? ilp_pkg::ST_RESET : st_d;
			if (leave && last_s1)
				res_v_s2 <= 1'b1;
			else if (pop)
				res_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave && last_s1)
			res_s2 <= res_d;
	end

	`ILP_ASSERT_IMP(a_num_capped, 1'b1,
		st_q.num_val <= ilp_pkg::MAG_CAP && st_q.bin_val <= ilp_pkg::MAG_CAP)
	`ILP_ASSERT_IMP(a_stop_bad_excl, 1'b1, !(st_q.stop && st_q.bad))
	`ILP_ASSERT_IMP(a_bin_closed, st_q.bin_found, !st_q.bin_open)
	`ILP_ASSERT_NEXT(a_clear_after_last, leave && last_s1,
		st_q.pos == 2'd0 && !st_q.ended && res_v_s2)

endmodule

`default_nettype wire

>>> design/ilp_out.sv
// ----------------------------------------------------------------------------
// ilp_out
// Applies sign and positive clamp, holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_literal_parser_assert.svh"

module ilp_out (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_v_s2,
	input  wire ilp_pkg::lit_res_t  res_s2,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [1:0]              kind,
	output logic signed [63:0]      value
);

	logic [63:0] val_d;

	assign pop = res_v_s2 && (!result_valid || !result_stall);

	always_comb begin
		if (res_s2.neg)
			val_d = 64'd0 - res_s2.mag; // cap magnitude wraps to the most negative value
		else if (res_s2.mag > ilp_pkg::POS_MAX)
			val_d = ilp_pkg::POS_MAX;
		else
			val_d = res_s2.mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			if (pop)
				result_valid <= 1'b1;
			else if (!result_stall)
				result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind  <= res_s2.kind;
			value <= $signed(val_d);
		end
	end

	`ILP_ASSERT_IMP(a_neg_is_dec, res_v_s2 && res_s2.neg, res_s2.kind == ilp_pkg::KIND_DEC)
	`ILP_ASSERT_IMP(a_invalid_zero, result_valid && kind == ilp_pkg::KIND_INVALID,
		value == 64'sd0)

endmodule

`default_nettype wire
